### src/segment_length_window_match_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the segment length window matcher.
// Each macro expands to a labelled concurrent assertion, or to nothing when
// NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_LENGTH_WINDOW_MATCH_ASSERT_SVH
`define SEGMENT_LENGTH_WINDOW_MATCH_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define SLWM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("segment_length_window_match: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SLWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("segment_length_window_match: next-cycle check failed");

`else

`define SLWM_ASSERT_SAME(label, clk, rst, ante, cons)
`define SLWM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### src/slwm_pkg.sv
// ---------------------------------------------------------------------------
// slwm_pkg
// Field widths, item and status codes and entry types shared by the
// segment length window matcher.
// ---------------------------------------------------------------------------
`default_nettype none

package slwm_pkg;

   localparam int FUNC_W  = 2;
   localparam int VIDEO_W = 16;
   localparam int RESO_W  = 8;
   localparam int SEG_W   = 10;
   localparam int LEN_W   = 24;
   localparam int PAY_W   = 25;
   localparam int STAT_W  = 3;

   // Item codes.
   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_STORED  = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
   localparam logic [STAT_W-1:0] ST_MATCH   = 3'd2;
   localparam logic [STAT_W-1:0] ST_NOMATCH = 3'd3;
   localparam logic [STAT_W-1:0] ST_CLEARED = 3'd4;

   // Header overhead added to a segment length.
   localparam logic [PAY_W-1:0] PAY_FIRST = 25'd508;
   localparam logic [PAY_W-1:0] PAY_LATER = 25'd884;

   // Window bounds relative to the observed length.
   localparam int CMP_W = PAY_W + 1;
   localparam logic [CMP_W-1:0] WIN_LOW_BELOW  = 26'd28;
   localparam logic [CMP_W-1:0] WIN_LOW_ABOVE  = 26'd12;
   localparam logic [CMP_W-1:0] WIN_HIGH_START = 26'd30;
   localparam logic [CMP_W-1:0] WIN_HIGH_END   = 26'd39;

   typedef struct packed {
      logic [VIDEO_W-1:0] video;
      logic [RESO_W-1:0]  reso;
      logic [SEG_W-1:0]   seg;
      logic [PAY_W-1:0]   payload;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [STAT_W-1:0] status;
      entry_type         entry;
      logic              last;
   } result_type;

endpackage

`default_nettype wire

### src/slwm_req_if.sv
// ---------------------------------------------------------------------------
// slwm_req_if
// Input channel of the matcher: valid/ready handshake and one item.
// ---------------------------------------------------------------------------
`default_nettype none

interface slwm_req_if import slwm_pkg::*; ();

   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [VIDEO_W-1:0] video_num;
   logic [RESO_W-1:0]  reso_id;
   logic [SEG_W-1:0]   seg_index;
   logic [LEN_W-1:0]   seg_len;
   logic [LEN_W-1:0]   query_len;

   modport source (
      output valid, func, video_num, reso_id, seg_index, seg_len, query_len,
      input  ready
   );

   modport sink (
      input  valid, func, video_num, reso_id, seg_index, seg_len, query_len,
      output ready
   );

endinterface

`default_nettype wire

### src/slwm_rsp_if.sv
// ---------------------------------------------------------------------------
// slwm_rsp_if
// Result channel of the matcher: valid/ready handshake and one result.
// ---------------------------------------------------------------------------
`default_nettype none

interface slwm_rsp_if import slwm_pkg::*; ();

   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [VIDEO_W-1:0] match_video;
   logic [RESO_W-1:0]  match_reso;
   logic [SEG_W-1:0]   match_seg;
   logic [PAY_W-1:0]   match_payload;
   logic               last;

   modport source (
      output valid, status, match_video, match_reso, match_seg, match_payload, last,
      input  ready
   );

   modport sink (
      input  valid, status, match_video, match_reso, match_seg, match_payload, last,
      output ready
   );

endinterface

`default_nettype wire

### src/slwm_ram.sv
// ---------------------------------------------------------------------------
// slwm_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module slwm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### src/slwm_window.sv
// ---------------------------------------------------------------------------
// slwm_window
// Compare unit: tells whether a stored payload length lies in either of the
// two windows around an observed length.
// ---------------------------------------------------------------------------
`default_nettype none

module slwm_window import slwm_pkg::*; (
   input  wire logic [PAY_W-1:0] payload,
   input  wire logic [LEN_W-1:0] query_len,
   output logic                  hit
);

   logic [CMP_W-1:0] pay_ext;
   logic [CMP_W-1:0] len_ext;
   logic             low_hit;
   logic             high_hit;

   // Sums are one bit wider than the payload, so none of them can wrap.
   always_comb begin
      pay_ext  = {1'b0, payload};
      len_ext  = {{(CMP_W - LEN_W){1'b0}}, query_len};
      low_hit  = (pay_ext + WIN_LOW_BELOW >= len_ext) &&
                 (pay_ext <= len_ext + WIN_LOW_ABOVE);
      high_hit = (pay_ext >= len_ext + WIN_HIGH_START) &&
                 (pay_ext <= len_ext + WIN_HIGH_END);
      hit      = low_hit || high_hit;
   end

endmodule

`default_nettype wire

### src/segment_length_window_match.sv
// ---------------------------------------------------------------------------
// segment_length_window_match
// Table of segment entries with a window match over the stored payloads.
// ---------------------------------------------------------------------------
// Items arrive on req_ch and results leave on rsp_ch, both valid/ready; a
// transfer takes place on a clock edge with valid and ready high.
// A load stores seg_len plus the header overhead (508 for segment 0, 884
// otherwise) and returns one stored or table-full result. A clear empties the
// table and returns one cleared result. Code 3 is dropped without a result.
// A query walks the table in order, each entry through a RAM read state
// (S_READ) and then the shared window compare (S_CHECK), and returns one match
// result per hit or a single no-match result; the final result has last set.
// The block takes one item at a time: req_ch.ready is high only while no
// item is in work.
// The result register lets a new item in while the previous result waits.
// When rsp_ch stalls, the scan pauses on the next hit until the result
// register is free; nothing is lost or reordered.
// Reset empties the table (count to zero) and drops any pending result. The
// RAM is not cleared; only entries below the count are ever read.
// ---------------------------------------------------------------------------
`default_nettype none
`include "segment_length_window_match_assert.svh"

module segment_length_window_match import slwm_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input wire logic    clock,
   input wire logic    reset,
   slwm_req_if.sink    req_ch,
   slwm_rsp_if.source  rsp_ch
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_LOAD   = 6'b000010,
      S_CLEAR  = 6'b000100,
      S_READ   = 6'b001000,
      S_CHECK  = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] idx_next;
   entry_type        item_ff, item_in;
   logic [LEN_W-1:0] qlen_ff, qlen_in;
   entry_type        hold_ff, hold_in;
   logic             hold_valid_ff, hold_valid_in;
   result_type       rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             slot_free;
   logic             emit;
   result_type       emit_data;
   logic             ram_we;
   entry_type        ram_rd_data;
   logic [ENTRY_W-1:0] ram_rd_bits;
   logic             hit;
   logic             req_take;
   logic [PAY_W-1:0] load_payload;

   slwm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (item_ff),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_bits)
   );

   assign ram_rd_data = entry_type'(ram_rd_bits);

   slwm_window u_window (
      .payload   (ram_rd_data.payload),
      .query_len (qlen_ff),
      .hit       (hit)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && (state_ff == S_IDLE);
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign idx_next     = idx_ff + CNT_W'(1);
   assign load_payload = {1'b0, req_ch.seg_len} +
                         ((req_ch.seg_index == '0) ? PAY_FIRST : PAY_LATER);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      item_in       = item_ff;
      qlen_in       = qlen_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      ram_we        = 1'b0;
      emit          = 1'b0;
      emit_data     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               item_in.video   = req_ch.video_num;
               item_in.reso    = req_ch.reso_id;
               item_in.seg     = req_ch.seg_index;
               item_in.payload = load_payload;
               qlen_in         = req_ch.query_len;
               idx_in          = '0;
               hold_valid_in   = 1'b0;
               unique case (req_ch.func)
                  FUNC_LOAD:  state_in = S_LOAD;
                  FUNC_QUERY: state_in = (count_ff == '0) ? S_FINISH : S_READ;
                  FUNC_CLEAR: state_in = S_CLEAR;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_LOAD: begin
            if (slot_free) begin
               emit           = 1'b1;
               emit_data.last = 1'b1;
               if (count_ff < CNT_FULL) begin
                  ram_we           = 1'b1;
                  count_in         = count_ff + CNT_W'(1);
                  emit_data.status = ST_STORED;
                  emit_data.entry  = item_ff;
               end else begin
                  emit_data.status = ST_FULL;
               end
               state_in = S_IDLE;
            end
         end
         S_CLEAR: begin
            if (slot_free) begin
               emit             = 1'b1;
               emit_data.status = ST_CLEARED;
               emit_data.last   = 1'b1;
               count_in         = '0;
               state_in         = S_IDLE;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            // A hit pushes out the previously held match, so it has to wait
            // for room in the result register; the read data stays put.
            if (!(hit && hold_valid_ff && !slot_free)) begin
               if (hit) begin
                  if (hold_valid_ff) begin
                     emit             = 1'b1;
                     emit_data.status = ST_MATCH;
                     emit_data.entry  = hold_ff;
                  end
                  hold_in       = ram_rd_data;
                  hold_valid_in = 1'b1;
               end
               idx_in   = idx_next;
               state_in = (idx_next == count_ff) ? S_FINISH : S_READ;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               emit           = 1'b1;
               emit_data.last = 1'b1;
               if (hold_valid_ff) begin
                  emit_data.status = ST_MATCH;
                  emit_data.entry  = hold_ff;
               end else begin
                  emit_data.status = ST_NOMATCH;
               end
               hold_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (emit) begin
         rsp_in       = emit_data;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff  <= idx_in;
      item_ff <= item_in;
      qlen_ff <= qlen_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_ff.status;
   assign rsp_ch.match_video   = rsp_ff.entry.video;
   assign rsp_ch.match_reso    = rsp_ff.entry.reso;
   assign rsp_ch.match_seg     = rsp_ff.entry.seg;
   assign rsp_ch.match_payload = rsp_ff.entry.payload;
   assign rsp_ch.last          = rsp_ff.last;

   `SLWM_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_FULL)
   `SLWM_ASSERT_SAME(a_scan_in_table, clock, reset,
      (state_ff == S_READ) || (state_ff == S_CHECK), idx_ff < count_ff)
   `SLWM_ASSERT_NEXT(a_write_counts, clock, reset, ram_we,
      count_ff == $past(count_ff) + CNT_W'(1))
   `SLWM_ASSERT_SAME(a_hold_in_query, clock, reset, hold_valid_ff,
      (state_ff == S_READ) || (state_ff == S_CHECK) || (state_ff == S_FINISH))

endmodule

`default_nettype wire

### dv/slwm_result_checker.sv
// ---------------------------------------------------------------------------
// slwm_result_checker
// Watches both channels of the segment length window matcher. It keeps its
// own copy of the segment table and works out the results of every accepted
// item. It compares each result transfer with the oldest expected result and
// counts the mismatches.
// ---------------------------------------------------------------------------
`default_nettype none

module slwm_result_checker import slwm_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   slwm_req_if        req_mon,
   slwm_rsp_if        rsp_mon,
   output int unsigned mismatch_count,
   output int unsigned results_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   entry_type   segment_table [TABLE_DEPTH];
   int unsigned entries_held = 0;
   int unsigned mismatches = 0;
   result_type  expected_results [$];

   function automatic bit payload_in_window(input logic [PAY_W-1:0] payload,
                                            input logic [LEN_W-1:0] observed);
      int unsigned p;
      int unsigned l;
      p = payload;
      l = observed;
      return ((p + WIN_LOW_BELOW >= l) && (p <= l + WIN_LOW_ABOVE)) ||
             ((p >= l + WIN_HIGH_START) && (p <= l + WIN_HIGH_END));
   endfunction

   task automatic predict_item(input logic [FUNC_W-1:0]  func,
                               input logic [VIDEO_W-1:0] video,
                               input logic [RESO_W-1:0]  reso,
                               input logic [SEG_W-1:0]   seg,
                               input logic [LEN_W-1:0]   seg_len,
                               input logic [LEN_W-1:0]   query_len);
      result_type  res;
      int unsigned hits;
      res      = '0;
      res.last = 1'b1;
      hits     = 0;
      case (func)
         FUNC_LOAD: begin
            if (entries_held < TABLE_DEPTH) begin
               res.status        = ST_STORED;
               res.entry.video   = video;
               res.entry.reso    = reso;
               res.entry.seg     = seg;
               res.entry.payload = (seg == '0) ? PAY_W'(seg_len) + PAY_FIRST
                                               : PAY_W'(seg_len) + PAY_LATER;
               segment_table[entries_held] = res.entry;
               entries_held++;
            end else begin
               res.status = ST_FULL;
            end
            expected_results.insert(expected_results.size(), res);
         end
         FUNC_QUERY: begin
            for (int i = 0; i < entries_held; i++) begin
               if (payload_in_window(segment_table[i].payload, query_len)) begin
                  res.status = ST_MATCH;
                  res.entry  = segment_table[i];
                  res.last   = 1'b0;
                  expected_results.insert(expected_results.size(), res);
                  hits++;
               end
            end
            if (hits == 0) begin
               res        = '0;
               res.status = ST_NOMATCH;
               res.last   = 1'b1;
               expected_results.insert(expected_results.size(), res);
            end else begin
               expected_results[$].last = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            entries_held = 0;
            res.status   = ST_CLEARED;
            expected_results.insert(expected_results.size(), res);
         end
         default: begin
            // The spare item code is dropped by the block without a result.
         end
      endcase
   endtask

   task automatic check_result();
      result_type want;
      if (expected_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: result with nothing expected: status %0d video %0d reso %0d",
                     $realtime, rsp_mon.status, rsp_mon.match_video, rsp_mon.match_reso);
         return;
      end
      want = expected_results.pop_front();
      if (rsp_mon.status !== want.status || rsp_mon.match_video !== want.entry.video ||
          rsp_mon.match_reso !== want.entry.reso || rsp_mon.match_seg !== want.entry.seg ||
          rsp_mon.match_payload !== want.entry.payload || rsp_mon.last !== want.last) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: result mismatch", $realtime);
            $display("   expected status %0d video %0d reso %0d seg %0d payload %0d last %0d",
                     want.status, want.entry.video, want.entry.reso, want.entry.seg,
                     want.entry.payload, want.last);
            $display("   actual   status %0d video %0d reso %0d seg %0d payload %0d last %0d",
                     rsp_mon.status, rsp_mon.match_video, rsp_mon.match_reso,
                     rsp_mon.match_seg, rsp_mon.match_payload, rsp_mon.last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         entries_held = 0;
         expected_results.delete();
      end else begin
         // A result never leaves on the edge that brings in its own item, so
         // the result transfer is checked first.
         if (rsp_mon.valid && rsp_mon.ready)
            check_result();
         if (req_mon.valid && req_mon.ready)
            predict_item(req_mon.func, req_mon.video_num, req_mon.reso_id,
                         req_mon.seg_index, req_mon.seg_len, req_mon.query_len);
      end
      mismatch_count      <= mismatches;
      results_outstanding <= expected_results.size();
   end

endmodule

`default_nettype wire

### dv/tb_segment_length_window_match.sv
// ---------------------------------------------------------------------------
// tb_segment_length_window_match
// Drives loads, queries and clears into the segment length window matcher.
// A directed opening covers the window edges, the largest fields, the spare
// item code and clearing. Random episodes then build clustered tables, fill
// them past full and query around the cluster, with random gaps and stalls
// on both channels and one long stall on the result side.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_segment_length_window_match;
   import slwm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 64;
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
   localparam int unsigned ITEM_TARGET  = 430;
   localparam int unsigned STEADY_FROM  = 370;
   localparam int unsigned HOLD_AFTER   = 120;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned TAIL_CYCLES  = 200;
   localparam int unsigned CYCLE_LIMIT  = 1000000;

   logic clock;
   logic reset;

   int unsigned items_sent = 0;
   bit          steady = 1'b0;
   bit          hold_done = 1'b0;
   int unsigned cycle_count;
   int unsigned mismatch_count;
   int unsigned results_outstanding;

   slwm_req_if req_bus ();
   slwm_rsp_if rsp_bus ();

   segment_length_window_match #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   slwm_result_checker #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_mon             (req_bus),
      .rsp_mon             (rsp_bus),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // Result side: random stall bursts, one long hold-off so that the block
   // backs up into its input, and no stalls in the last part of the run.
   initial begin
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (!hold_done && items_sent >= HOLD_AFTER) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (steady) begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   task automatic send_item(input logic [FUNC_W-1:0]  func,
                            input logic [VIDEO_W-1:0] video,
                            input logic [RESO_W-1:0]  reso,
                            input logic [SEG_W-1:0]   seg,
                            input logic [LEN_W-1:0]   seg_len,
                            input logic [LEN_W-1:0]   query_len);
      req_bus.valid     <= 1'b1;
      req_bus.func      <= func;
      req_bus.video_num <= video;
      req_bus.reso_id   <= reso;
      req_bus.seg_index <= seg;
      req_bus.seg_len   <= seg_len;
      req_bus.query_len <= query_len;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
      if (!steady && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic load_entry(input logic [VIDEO_W-1:0] video, input logic [RESO_W-1:0] reso,
                             input logic [SEG_W-1:0] seg, input logic [LEN_W-1:0] seg_len);
      send_item(FUNC_LOAD, video, reso, seg, seg_len, LEN_W'($urandom));
   endtask

   task automatic query_length(input logic [LEN_W-1:0] query_len);
      send_item(FUNC_QUERY, VIDEO_W'($urandom), RESO_W'($urandom), SEG_W'($urandom),
                LEN_W'($urandom), query_len);
   endtask

   task automatic clear_table();
      send_item(FUNC_CLEAR, VIDEO_W'($urandom), RESO_W'($urandom), SEG_W'($urandom),
                LEN_W'($urandom), LEN_W'($urandom));
   endtask

   task automatic send_spare();
      send_item(FUNC_SPARE, VIDEO_W'($urandom), RESO_W'($urandom), SEG_W'($urandom),
                LEN_W'($urandom), LEN_W'($urandom));
   endtask

   // One episode: optionally clear, load entries whose payloads cluster around
   // a centre, then query around that centre, with some noise mixed in.
   task automatic run_episode();
      int unsigned centre;
      int unsigned target;
      int unsigned loads;
      int unsigned queries;
      logic [SEG_W-1:0] seg;
      centre = $urandom_range(1000, 16776000);
      if ($urandom_range(0, 3) != 0)
         clear_table();
      loads = ($urandom_range(0, 5) == 0) ? $urandom_range(TABLE_DEPTH, TABLE_DEPTH + 4)
                                          : $urandom_range(1, 10);
      repeat (loads) begin
         if ($urandom_range(0, 9) == 0) begin
            load_entry(VIDEO_W'($urandom), RESO_W'($urandom), SEG_W'($urandom),
                       LEN_W'($urandom));
         end else begin
            seg    = ($urandom_range(0, 2) == 0) ? '0 : SEG_W'($urandom_range(1, 1023));
            target = centre + $urandom_range(0, 60);
            load_entry(VIDEO_W'($urandom), RESO_W'($urandom), seg,
                       LEN_W'(target - ((seg == '0) ? 508 : 884)));
         end
         if ($urandom_range(0, 7) == 0)
            query_length(LEN_W'(centre + $urandom_range(0, 140) - 50));
      end
      queries = $urandom_range(2, 6);
      repeat (queries) begin
         case ($urandom_range(0, 11))
            0:       query_length(LEN_W'($urandom));
            1:       send_spare();
            default: query_length(LEN_W'(centre + $urandom_range(0, 140) - 50));
         endcase
      end
   endtask

   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.func      <= FUNC_LOAD;
      req_bus.video_num <= '0;
      req_bus.reso_id   <= '0;
      req_bus.seg_index <= '0;
      req_bus.seg_len   <= '0;
      req_bus.query_len <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening. The entry with payload 1884 sets the window edges:
      // the low window spans queries 1872 to 1912, the high one 1845 to 1854.
      query_length(24'd0);
      send_spare();
      load_entry(16'd0, 8'd0, 10'd0, 24'd0);
      load_entry(16'hFFFF, 8'hFF, 10'd1023, 24'hFFFFFF);
      load_entry(16'h1234, 8'h5A, 10'd1, 24'd1000);
      query_length(24'd1912);
      query_length(24'd1913);
      query_length(24'd1872);
      query_length(24'd1871);
      query_length(24'd1854);
      query_length(24'd1845);
      query_length(24'd1844);
      query_length(24'd1855);
      query_length(24'd480);
      query_length(24'd0);
      query_length(24'hFFFFFF);
      send_spare();
      load_entry(16'd7, 8'd3, 10'd0, 24'd1376);
      query_length(24'd1884);
      clear_table();
      query_length(24'd1884);

      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= STEADY_FROM)
            steady = 1'b1;
         run_episode();
      end
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (results_outstanding != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

### files.f
+incdir+src
src/slwm_pkg.sv
src/slwm_req_if.sv
src/slwm_rsp_if.sv
src/slwm_ram.sv
src/slwm_window.sv
src/segment_length_window_match.sv
dv/slwm_result_checker.sv
dv/tb_segment_length_window_match.sv
